// ----- hw/rtl/jsfe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types and constants of the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

  // Field name window sizing
  localparam int MAX_FIELD_BYTES = 8;
  localparam int WIN_DEPTH       = MAX_FIELD_BYTES + 2;
  localparam int SEEN_W          = $clog2(WIN_DEPTH + 1);
  localparam int NAME_W          = 8 * MAX_FIELD_BYTES;
  localparam int LEN_W           = 4;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_NAME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LENGTH = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Results one input byte can cause, and the group queue depth
  localparam int GRP_ITEMS = 4;
  localparam int GRP_CNT_W = $clog2(GRP_ITEMS + 1);
  localparam int GRP_SEL_W = $clog2(GRP_ITEMS);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_COLON  = 3'd1,
    PH_WS     = 3'd2,
    PH_STRING = 3'd3,
    PH_ESC    = 3'd4,
    PH_HEX    = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       out_last;
  } out_item_t;

  // One result without its last flag
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } res_t;

  // All results of one input byte
  typedef struct packed {
    res_t [GRP_ITEMS-1:0]  item;
    logic [GRP_CNT_W-1:0]  cnt;
  } group_t;

endpackage
`default_nettype wire

// ----- hw/rtl/json_string_field_extractor_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_field_extractor_top
// Finds a quoted field name in a JSON byte stream and emits its string value.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one JSON text byte per request, in_last on the final byte.
//   out_* : decoded bytes (status data), then one ok or fail report; out_last
//           marks the final result caused by a given input byte.
//   cfg_* : field_name (index 0) and field_length (index 1); cfg_ready is
//           always high. Write only while the block is idle.
// Timing: one byte is taken per cycle while in_stall is low. A byte is held
//   in the input register, is parsed and pushed as a group of 0 to 4
//   results into a 4-entry group queue; its first result is valid once
//   the group is queued.
//   The output side drains one result per cycle while out_stall is low;
//   a byte with several results (a \u escape, or a fail added by in_last)
//   holds the queue head until all of its results are taken.
// Stall: out_stall holds the head result; once the queue fills, in_stall
//   rises and the input register keeps its byte.
// Reset: parser returns to name search, queue empties, registers clear.
// ----------------------------------------------------------------------------
module json_string_field_extractor_top (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  jsfe_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output jsfe_pkg::out_item_t             out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [jsfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [jsfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jsfe_pkg::*;

  logic [NAME_W-1:0]   name_r;
  logic [LEN_W-1:0]    len_r;
  logic                in_v_r;
  in_item_t            in_d_r;
  logic                go;
  group_t              grp;
  group_t [QDEPTH-1:0] q_r;
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QCNT_W-1:0]   fill_r, fill_nxt;
  logic [GRP_SEL_W-1:0] sel_r;
  logic                push, pop, out_take, q_full;
  group_t              head;
  res_t                head_res;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r <= '0;
      len_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FIELD_NAME) begin
        name_r <= cfg_data[NAME_W-1:0];
      end
      if (cfg_index == CFG_FIELD_LENGTH) begin
        len_r <= cfg_data[LEN_W-1:0];
      end
    end
  end

  // Input register
  assign q_full   = (fill_r == QCNT_W'(QDEPTH));
  assign go       = in_v_r && !q_full;
  assign in_stall = in_v_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_d_r <= in_data;
    end
  end

  jsfe_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (go),
    .item         (in_d_r),
    .field_name   (name_r),
    .field_length (len_r),
    .grp          (grp)
  );

  // Group queue
  assign push     = go && (grp.cnt != '0);
  assign head     = q_r[rd_r];
  assign head_res = head.item[sel_r];
  assign out_valid = (fill_r != '0);
  assign out_take  = out_valid && !out_stall;
  assign pop       = out_take && (GRP_CNT_W'(sel_r) == head.cnt - 1'b1);

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
      sel_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r  <= rd_r + 1'b1;
        sel_r <= '0;
      end else if (out_take) begin
        sel_r <= sel_r + 1'b1;
      end
    end
  end

  // Output payload straight from the queue head
  assign out_data.out_byte = head_res.data;
  assign out_data.status   = head_res.status;
  assign out_data.out_last = (GRP_CNT_W'(sel_r) == head.cnt - 1'b1);

`ifndef NO_ASSERTIONS
  // A queued group never holds zero results
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.cnt != '0))
    else $error("empty group at queue head");

  // Ok and fail reports always close their group
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DATA) |-> out_data.out_last)
    else $error("status report not marked last");

  // Fill count never exceeds the queue depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QCNT_W'(QDEPTH))
    else $error("group queue overflow");

  // A push into a full queue cannot happen
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push while queue full");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/jsfe_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsfe_decode
// Per-byte parser: name search, colon and whitespace skip, string unescape.
// ----------------------------------------------------------------------------
module jsfe_decode (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          go,
  input  jsfe_pkg::in_item_t           item,
  input  wire [jsfe_pkg::NAME_W-1:0]   field_name,
  input  wire [jsfe_pkg::LEN_W-1:0]    field_length,
  output jsfe_pkg::group_t             grp
);
  import jsfe_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;

  logic [WIN_DEPTH-1:0][7:0]       win_r, win_nxt, shift_win;
  logic [SEEN_W-1:0]               seen_r, seen_nxt, seen_inc;
  phase_t                          ph_r, ph_nxt;
  logic [15:0]                     acc_r, acc_nxt, acc_sh;
  logic [1:0]                      dig_r, dig_nxt;
  logic [MAX_FIELD_BYTES-1:0][7:0] name_b;
  logic [LEN_W-1:0]                len_c;
  logic [SEEN_W-1:0]               total;
  logic [WIN_DEPTH-1:0]            pos_ok;
  logic                            hit;
  logic [3:0]                      hval;
  logic                            hvalid;
  logic [7:0]                      c;
  res_t [GRP_ITEMS-1:0]            items;
  logic [GRP_CNT_W-1:0]            nres;
  logic [SEEN_W-1:0]               ofs;

  assign c      = item.in_byte;
  assign name_b = field_name;

  // Hex digit value
  always_comb begin
    hvalid = 1'b1;
    hval   = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hval = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hval = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hval = 4'(c - 8'h37);
    end else begin
      hvalid = 1'b0;
    end
  end

  // Window compare against "name", newest byte at position 0
  always_comb begin
    shift_win = {win_r[WIN_DEPTH-2:0], c};
    seen_inc  = (seen_r < SEEN_W'(WIN_DEPTH)) ? seen_r + 1'b1 : seen_r;
    len_c     = (field_length > LEN_W'(MAX_FIELD_BYTES)) ?
                LEN_W'(MAX_FIELD_BYTES) : field_length;
    total     = SEEN_W'(len_c) + SEEN_W'(2);
    for (int k = 0; k < WIN_DEPTH; k++) begin
      ofs = total - SEEN_W'(2) - SEEN_W'(k);
      if (SEEN_W'(k) >= total) begin
        pos_ok[k] = 1'b1;
      end else if (k == 0 || SEEN_W'(k) == total - 1'b1) begin
        pos_ok[k] = (shift_win[k] == CH_QUOTE);
      end else begin
        pos_ok[k] = (shift_win[k] == name_b[ofs[$clog2(MAX_FIELD_BYTES)-1:0]]);
      end
    end
    hit = (seen_inc >= total) && (&pos_ok);
  end

  // Next state and results
  always_comb begin
    win_nxt  = win_r;
    seen_nxt = seen_r;
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    dig_nxt  = dig_r;
    items    = '0;
    nres     = '0;
    acc_sh   = {acc_r[11:0], hval};

    unique case (ph_r)
      PH_SEARCH: begin
        win_nxt  = shift_win;
        seen_nxt = seen_inc;
        if (hit) begin
          ph_nxt = PH_COLON;
        end
      end
      PH_COLON: begin
        if (c == CH_COLON) begin
          ph_nxt = PH_WS;
        end
      end
      PH_WS: begin
        if (c == CH_QUOTE) begin
          ph_nxt = PH_STRING;
        end else if (c != 8'h20 && c != 8'h09 && c != 8'h0D && c != 8'h0A) begin
          items[0] = '{8'h00, ST_FAIL};
          nres     = GRP_CNT_W'(1);
          ph_nxt   = PH_DONE;
        end
      end
      PH_STRING: begin
        if (c == CH_QUOTE) begin
          items[0] = '{8'h00, ST_OK};
          nres     = GRP_CNT_W'(1);
          ph_nxt   = PH_DONE;
        end else if (c == CH_BSL) begin
          ph_nxt = PH_ESC;
        end else begin
          items[0] = '{c, ST_DATA};
          nres     = GRP_CNT_W'(1);
        end
      end
      PH_ESC: begin
        ph_nxt   = PH_STRING;
        nres     = GRP_CNT_W'(1);
        case (c)
          CH_QUOTE, CH_BSL, 8'h2F: items[0] = '{c, ST_DATA};
          8'h62: items[0] = '{8'h08, ST_DATA};
          8'h66: items[0] = '{8'h0C, ST_DATA};
          8'h6E: items[0] = '{8'h0A, ST_DATA};
          8'h72: items[0] = '{8'h0D, ST_DATA};
          8'h74: items[0] = '{8'h09, ST_DATA};
          8'h75: begin
            nres    = '0;
            acc_nxt = '0;
            dig_nxt = '0;
            ph_nxt  = PH_HEX;
          end
          default: begin
            items[0] = '{8'h00, ST_FAIL};
            ph_nxt   = PH_DONE;
          end
        endcase
      end
      PH_HEX: begin
        if (!hvalid) begin
          items[0] = '{8'h00, ST_FAIL};
          nres     = GRP_CNT_W'(1);
          ph_nxt   = PH_DONE;
        end else begin
          acc_nxt = acc_sh;
          if (dig_r == 2'd3) begin
            dig_nxt = '0;
            ph_nxt  = PH_STRING;
            // UTF-8 encode, at most three bytes
            if (acc_sh <= 16'h007F) begin
              items[0] = '{acc_sh[7:0], ST_DATA};
              nres     = GRP_CNT_W'(1);
            end else if (acc_sh <= 16'h07FF) begin
              items[0] = '{8'hC0 | {3'b000, acc_sh[10:6]}, ST_DATA};
              items[1] = '{8'h80 | {2'b00, acc_sh[5:0]}, ST_DATA};
              nres     = GRP_CNT_W'(2);
            end else begin
              items[0] = '{8'hE0 | {4'b0000, acc_sh[15:12]}, ST_DATA};
              items[1] = '{8'h80 | {2'b00, acc_sh[11:6]}, ST_DATA};
              items[2] = '{8'h80 | {2'b00, acc_sh[5:0]}, ST_DATA};
              nres     = GRP_CNT_W'(3);
            end
          end else begin
            dig_nxt = dig_r + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    // End of text: report fail if nothing final was reported, then restart
    if (item.in_last) begin
      if (ph_nxt != PH_DONE) begin
        items[nres[GRP_SEL_W-1:0]] = '{8'h00, ST_FAIL};
        nres = nres + 1'b1;
      end
      win_nxt  = '0;
      seen_nxt = '0;
      ph_nxt   = PH_SEARCH;
      acc_nxt  = '0;
      dig_nxt  = '0;
    end

    grp.item = items;
    grp.cnt  = nres;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      seen_r <= '0;
      ph_r   <= PH_SEARCH;
      acc_r  <= '0;
      dig_r  <= '0;
    end else if (go) begin
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
      ph_r   <= ph_nxt;
      acc_r  <= acc_nxt;
      dig_r  <= dig_nxt;
    end
  end

endmodule
`default_nettype wire
